// File: hw/rtl/mea_pkg.sv
// shared types, operation codes and constants of the execute alu
package mea_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 6;
  localparam int unsigned LinkReg = 31;

  typedef enum logic [KindW-1:0] {
    K_LI = 6'd0, K_ADD = 6'd1, K_SUB = 6'd2, K_MUL = 6'd3, K_DIV = 6'd4, K_REM = 6'd5,
    K_XOR = 6'd6, K_SEQ = 6'd7, K_SNE = 6'd8, K_SLE = 6'd9, K_SLT = 6'd10, K_SGE = 6'd11,
    K_SGT = 6'd12, K_ADDU = 6'd13, K_SUBU = 6'd14, K_MULU = 6'd15, K_DIVU = 6'd16,
    K_REMU = 6'd17, K_XORU = 6'd18, K_WMUL = 6'd19, K_WDIV = 6'd20, K_WMULU = 6'd21,
    K_WDIVU = 6'd22, K_NEG = 6'd23, K_NOT = 6'd24, K_J = 6'd25, K_BEQ = 6'd26,
    K_BNE = 6'd27, K_BLE = 6'd28, K_BLT = 6'd29, K_BGE = 6'd30, K_BGT = 6'd31,
    K_BEQZ = 6'd32, K_BNEZ = 6'd33, K_BLEZ = 6'd34, K_BLTZ = 6'd35, K_BGEZ = 6'd36,
    K_BGTZ = 6'd37, K_JR = 6'd38, K_JAL = 6'd39, K_JALR = 6'd40, K_ADDR = 6'd41,
    K_MOVE = 6'd42, K_MFLO = 6'd43, K_MFHI = 6'd44
  } kind_t;

  // command from the sequencer to the shared iterative unit
  typedef struct packed {
    logic start;
    logic is_div;
    logic sgn;
  } iter_cmd_t;

endpackage

// File: hw/rtl/mea_iter.sv
// shared shift-add multiplier and restoring divider, one bit per cycle
module mea_iter import mea_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  iter_cmd_t        cmd,
  input  logic [DataW-1:0] a,
  input  logic [DataW-1:0] b,
  output logic             done,
  output logic [2*DataW-1:0] prod,
  output logic [2*DataW-1:0] quot,
  output logic [DataW-1:0] rem
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               div_r, div_nxt;
  logic               neg_q_r, neg_q_nxt;
  logic               neg_r_r, neg_r_nxt;
  logic [DataW-1:0]   mag_b_r, mag_b_nxt;
  logic [2*DataW-1:0] acc_r, acc_nxt;   // mul: product / div: rem:quot
  logic [DataW:0]     trial;
  logic [DataW-1:0]   ma, mb;
  logic [DataW-1:0]   addend;
  logic [2*DataW-1:0] q_ext;
  logic [DataW-1:0]   r_ext;

  always_comb begin
    ma = (cmd.sgn && a[DataW-1]) ? (~a + 1'b1) : a;
    mb = (cmd.sgn && b[DataW-1]) ? (~b + 1'b1) : b;
    trial = {acc_r[2*DataW-1:DataW], acc_r[DataW-1]} - {1'b0, mag_b_r};
    addend = acc_r[0] ? mag_b_r : {DataW{1'b0}};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    mag_b_nxt = mag_b_r;
    acc_nxt = acc_r;
    done = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      div_nxt = cmd.is_div;
      neg_q_nxt = cmd.sgn && (a[DataW-1] ^ b[DataW-1]);
      neg_r_nxt = cmd.sgn && a[DataW-1];
      mag_b_nxt = mb;
      acc_nxt = {{DataW{1'b0}}, ma};
    end else if (busy_r) begin
      if (cnt_r == CntW'(DataW)) begin
        busy_nxt = 1'b0;
        done = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (div_r) begin
          if (!trial[DataW])
            acc_nxt = {trial[DataW-1:0], acc_r[DataW-2:0], 1'b1};
          else
            acc_nxt = {acc_r[2*DataW-2:0], 1'b0};
        end else begin
          acc_nxt = {{1'b0, acc_r[2*DataW-1:DataW]} + {1'b0, addend},
                     acc_r[DataW-1:1]};
        end
      end
    end
    q_ext = {{DataW{1'b0}}, acc_r[DataW-1:0]};
    r_ext = acc_r[2*DataW-1:DataW];
    prod = neg_q_r ? (~acc_r + 1'b1) : acc_r;
    quot = neg_q_r ? (~q_ext + 1'b1) : q_ext;
    rem  = neg_r_r ? (~r_ext + 1'b1) : r_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    div_r <= div_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    mag_b_r <= mag_b_nxt;
    acc_r <= acc_nxt;
  end

endmodule

// File: hw/rtl/mips_execute_alu_unit.sv
// execute stage alu: decode, combinational simple ops and sequencer for the iterative unit
//
// one input channel (in_valid/in_stall) carries a decoded operation with its
// operands; one result channel (out_valid/out_stall) returns result, taken
// and link for every operation, in order.
// the block takes one item at a time: in_stall is high from acceptance until
// the result has been transferred.
// simple operations are computed from the registered operands and their result
// is registered. multiply, divide and remainder (narrow and wide) run
// through one shared radix-2 shift-add / restoring-divide unit, except for a
// zero divisor: load, one iteration per operand bit and a finishing step.
// the result waits in an output register while out_stall is high; the
// next item is taken in the cycle after that result's transfer.
// synchronous reset clears the control state and the wide low/high pair.
module mips_execute_alu_unit import mea_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [KindW-1:0] in_kind,
  input  logic             in_use_imm,
  input  logic signed [DataW-1:0] in_operand_a,
  input  logic signed [DataW-1:0] in_operand_b,
  input  logic signed [DataW-1:0] in_immediate,
  input  logic [DataW-1:0] in_target,
  output logic             out_valid,
  input  logic             out_stall,
  output logic signed [DataW-1:0] out_result,
  output logic             out_taken,
  output logic             out_link
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ITER, S_OUT} state_t;

  state_t           state_r;
  kind_t            kind_r;
  logic             imm_r;
  logic [DataW-1:0] a_r, b_r, imm_v_r, tgt_r;
  logic [DataW-1:0] wlo_r, whi_r;
  logic [DataW-1:0] res_r;
  logic             taken_r, link_r;

  logic [DataW-1:0] s;
  logic             lt, eq, ltz, eqz, cmp, zdiv;
  logic [DataW-1:0] res_c;
  logic             taken_c, link_c, is_iter, is_div, is_sgn;
  iter_cmd_t        cmd;
  logic             it_done;
  logic [2*DataW-1:0] it_prod, it_quot;
  logic [DataW-1:0] it_rem;

  always_comb begin
    s = imm_r ? imm_v_r : b_r;
    eq = (a_r == s);
    lt = ($signed(a_r) < $signed(s));
    eqz = (a_r == '0);
    ltz = a_r[DataW-1];
    zdiv = (s == '0);
    is_iter = 1'b0;
    is_div = 1'b0;
    is_sgn = 1'b0;
    res_c = '0;
    taken_c = 1'b0;
    link_c = 1'b0;
    cmp = 1'b0;
    case (kind_r)
      K_LI:   res_c = imm_v_r;
      K_ADD, K_ADDU: res_c = a_r + s;
      K_SUB, K_SUBU: res_c = a_r - s;
      K_XOR, K_XORU: res_c = a_r ^ s;
      K_MUL, K_MULU, K_WMULU: is_iter = 1'b1;
      K_WMUL: begin is_iter = 1'b1; is_sgn = 1'b1; end
      K_DIV, K_REM, K_WDIV: begin
        is_iter = !zdiv; is_div = 1'b1; is_sgn = 1'b1;
      end
      K_DIVU, K_REMU, K_WDIVU: begin is_iter = !zdiv; is_div = 1'b1; end
      K_SEQ: res_c = DataW'(eq);
      K_SNE: res_c = DataW'(!eq);
      K_SLE: res_c = DataW'(lt || eq);
      K_SLT: res_c = DataW'(lt);
      K_SGE: res_c = DataW'(!lt);
      K_SGT: res_c = DataW'(!lt && !eq);
      K_NEG:  res_c = '0 - a_r;
      K_NOT:  res_c = ~a_r;
      K_J:    begin res_c = tgt_r; taken_c = 1'b1; end
      K_BEQ:  begin res_c = tgt_r; taken_c = eq; end
      K_BNE:  begin res_c = tgt_r; taken_c = !eq; end
      K_BLE:  begin res_c = tgt_r; taken_c = lt || eq; end
      K_BLT:  begin res_c = tgt_r; taken_c = lt; end
      K_BGE:  begin res_c = tgt_r; taken_c = !lt; end
      K_BGT:  begin res_c = tgt_r; taken_c = !lt && !eq; end
      K_BEQZ: begin res_c = tgt_r; taken_c = eqz; end
      K_BNEZ: begin res_c = tgt_r; taken_c = !eqz; end
      K_BLEZ: begin res_c = tgt_r; taken_c = ltz || eqz; end
      K_BLTZ: begin res_c = tgt_r; taken_c = ltz; end
      K_BGEZ: begin res_c = tgt_r; taken_c = !ltz; end
      K_BGTZ: begin res_c = tgt_r; taken_c = !ltz && !eqz; end
      K_JR:   begin res_c = a_r; taken_c = 1'b1; end
      K_JAL:  begin res_c = tgt_r; taken_c = 1'b1; link_c = (LinkReg == 31); end
      K_JALR: begin res_c = a_r; taken_c = 1'b1; link_c = (LinkReg == 31); end
      K_ADDR: res_c = imm_r ? imm_v_r : b_r + imm_v_r;
      K_MOVE: res_c = a_r;
      K_MFLO: res_c = wlo_r;
      K_MFHI: res_c = whi_r;
      default: res_c = '0;
    endcase
    cmd.start = (state_r == S_EXEC) && is_iter;
    cmd.is_div = is_div;
    cmd.sgn = is_sgn;
    cmp = cmd.start;
  end

  mea_iter u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .a    (a_r),
    .b    (s),
    .done (it_done),
    .prod (it_prod),
    .quot (it_quot),
    .rem  (it_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wlo_r <= '0;
      whi_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          kind_r <= kind_t'(in_kind);
          imm_r <= in_use_imm;
          a_r <= in_operand_a;
          b_r <= in_operand_b;
          imm_v_r <= in_immediate;
          tgt_r <= in_target;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          taken_r <= taken_c;
          link_r <= link_c;
          if (!cmp && is_div) begin
            // divide by zero: all-ones quotient, dividend remainder
            case (kind_r)
              K_DIV, K_DIVU: res_r <= '1;
              K_REM, K_REMU: res_r <= a_r;
              default: begin res_r <= res_c; wlo_r <= '1; whi_r <= '1; end
            endcase
          end else begin
            res_r <= res_c;
          end
          if (cmp) begin
            state_r <= S_ITER;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_ITER: if (it_done) begin
          case (kind_r)
            K_MUL, K_MULU: res_r <= it_prod[DataW-1:0];
            K_DIV, K_DIVU: res_r <= it_quot[DataW-1:0];
            K_REM, K_REMU: res_r <= it_rem;
            K_WMUL, K_WMULU: begin
              wlo_r <= it_prod[DataW-1:0]; whi_r <= it_prod[2*DataW-1:DataW];
            end
            default: begin
              wlo_r <= it_quot[DataW-1:0]; whi_r <= it_quot[2*DataW-1:DataW];
            end
          endcase
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_result = res_r;
  assign out_taken = taken_r;
  assign out_link = link_r;

endmodule

// File: sim/tb_mips_execute_alu_unit.sv
// self-checking testbench for the execute stage alu with its own prediction of every result
`timescale 1ns / 100ps

module tb_mips_execute_alu_unit;
  import mea_pkg::*;

  typedef struct {
    logic [KindW-1:0] kind;
    logic             use_imm;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] imm;
    logic [DataW-1:0] tgt;
  } alu_op_t;

  typedef struct {
    logic [DataW-1:0] result;
    logic             taken;
    logic             link;
  } alu_res_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned LongHold = 400;
  localparam logic [KindW-1:0] KindUnusedLo = KindW'(K_MFHI + 1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KindW-1:0] in_kind = '0;
  logic in_use_imm = 1'b0;
  logic signed [DataW-1:0] in_operand_a = '0;
  logic signed [DataW-1:0] in_operand_b = '0;
  logic signed [DataW-1:0] in_immediate = '0;
  logic [DataW-1:0] in_target = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DataW-1:0] out_result;
  logic out_taken;
  logic out_link;

  alu_res_t pending_q[$];
  logic [DataW-1:0] wide_lo = '0;
  logic [DataW-1:0] wide_hi = '0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned cycle_cnt = 0;
  bit failed = 1'b0;

  mips_execute_alu_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_use_imm  (in_use_imm),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .in_immediate(in_immediate),
    .in_target   (in_target),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result),
    .out_taken   (out_taken),
    .out_link    (out_link)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // expected outcome of one operation, updates the wide pair
  function automatic alu_res_t predict_op(alu_op_t op);
    alu_res_t r;
    logic [DataW-1:0] s;
    longint sa;
    longint sb;
    longint q;
    longint rm;
    longint unsigned wide;
    bit wide_wr;
    s = op.use_imm ? op.imm : op.b;
    sa = $signed(op.a);
    sb = $signed(s);
    // signed quotient and remainder, kept apart from unsigned operands
    q = (sb == 0) ? -64'sd1 : sa / sb;
    rm = (sb == 0) ? sa : sa % sb;
    wide = '0;
    wide_wr = 1'b0;
    r.result = '0;
    r.taken = 1'b0;
    r.link = 1'b0;
    case (op.kind)
      K_LI: r.result = op.imm;
      K_ADD, K_ADDU: r.result = op.a + s;
      K_SUB, K_SUBU: r.result = op.a - s;
      K_MUL, K_MULU: r.result = op.a * s;
      K_DIV: r.result = q[31:0];
      K_REM: r.result = rm[31:0];
      K_XOR, K_XORU: r.result = op.a ^ s;
      K_SEQ: r.result = DataW'(sa == sb);
      K_SNE: r.result = DataW'(sa != sb);
      K_SLE: r.result = DataW'(sa <= sb);
      K_SLT: r.result = DataW'(sa < sb);
      K_SGE: r.result = DataW'(sa >= sb);
      K_SGT: r.result = DataW'(sa > sb);
      K_DIVU: r.result = (s == 0) ? '1 : op.a / s;
      K_REMU: r.result = (s == 0) ? op.a : op.a % s;
      K_WMUL: begin wide = sa * sb; wide_wr = 1'b1; end
      K_WDIV: begin wide = q; wide_wr = 1'b1; end
      K_WMULU: begin wide = {32'b0, op.a} * {32'b0, s}; wide_wr = 1'b1; end
      K_WDIVU: begin wide = (s == 0) ? '1 : {32'b0, op.a} / {32'b0, s}; wide_wr = 1'b1; end
      K_NEG: r.result = -op.a;
      K_NOT: r.result = ~op.a;
      K_J: begin r.result = op.tgt; r.taken = 1'b1; end
      K_BEQ: begin r.result = op.tgt; r.taken = (sa == sb); end
      K_BNE: begin r.result = op.tgt; r.taken = (sa != sb); end
      K_BLE: begin r.result = op.tgt; r.taken = (sa <= sb); end
      K_BLT: begin r.result = op.tgt; r.taken = (sa < sb); end
      K_BGE: begin r.result = op.tgt; r.taken = (sa >= sb); end
      K_BGT: begin r.result = op.tgt; r.taken = (sa > sb); end
      K_BEQZ: begin r.result = op.tgt; r.taken = (sa == 0); end
      K_BNEZ: begin r.result = op.tgt; r.taken = (sa != 0); end
      K_BLEZ: begin r.result = op.tgt; r.taken = (sa <= 0); end
      K_BLTZ: begin r.result = op.tgt; r.taken = (sa < 0); end
      K_BGEZ: begin r.result = op.tgt; r.taken = (sa >= 0); end
      K_BGTZ: begin r.result = op.tgt; r.taken = (sa > 0); end
      K_JR: begin r.result = op.a; r.taken = 1'b1; end
      K_JAL: begin r.result = op.tgt; r.taken = 1'b1; r.link = (LinkReg == 31); end
      K_JALR: begin r.result = op.a; r.taken = 1'b1; r.link = (LinkReg == 31); end
      K_ADDR: r.result = op.use_imm ? op.imm : op.b + op.imm;
      K_MOVE: r.result = op.a;
      K_MFLO: r.result = wide_lo;
      K_MFHI: r.result = wide_hi;
      default: ;
    endcase
    if (wide_wr) begin
      wide_lo = wide[31:0];
      wide_hi = wide[63:32];
    end
    return r;
  endfunction

  // one transfer on the input channel; valid stays high when no gap follows
  task automatic send_op(alu_op_t op);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind <= op.kind;
    in_use_imm <= op.use_imm;
    in_operand_a <= op.a;
    in_operand_b <= op.b;
    in_immediate <= op.imm;
    in_target <= op.tgt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_op(op));
  endtask

  task automatic send_fields(logic [KindW-1:0] kind, logic use_imm, logic [31:0] a,
                             logic [31:0] b, logic [31:0] imm, logic [31:0] tgt);
    alu_op_t op;
    op = '{kind, use_imm, a, b, imm, tgt};
    send_op(op);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4, 5: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_op_t random_op();
    alu_op_t op;
    op.kind = KindW'(($urandom_range(0, 15) == 0) ? $urandom_range(KindUnusedLo, 63)
                                                  : $urandom_range(K_LI, K_MFHI));
    op.use_imm = 1'($urandom_range(0, 1));
    op.a = pick_word();
    op.b = ($urandom_range(0, 7) == 0) ? op.a : pick_word();
    op.imm = ($urandom_range(0, 7) == 0) ? op.a : pick_word();
    op.tgt = $urandom;
    return op;
  endfunction

  // receiver side: random hold-off per result, plus a long one on request
  initial begin
    int unsigned n;
    forever begin
      n = rx_idle ? $urandom_range(0, 16) : 0;
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("result transfer with no pending operation: result %h", out_result);
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (out_result !== e.result) begin
          $error("result: expected %h, actual %h", e.result, out_result);
          failed = 1'b1;
        end
        if (out_taken !== e.taken) begin
          $error("taken: expected %b, actual %b", e.taken, out_taken);
          failed = 1'b1;
        end
        if (out_link !== e.link) begin
          $error("link: expected %b, actual %b", e.link, out_link);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic test_pair_after_reset();
    send_fields(K_MFLO, 1'b0, 32'h1, 32'h2, 32'h3, 32'h4);
    send_fields(K_MFHI, 1'b1, 32'h1, 32'h2, 32'h3, 32'h4);
  endtask

  task automatic test_arith_edges();
    send_fields(K_LI, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_fields(K_ADD, 1'b0, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h0);
    send_fields(K_SUBU, 1'b1, 32'h8000_0000, 32'h0, 32'h1, 32'h0);
    send_fields(K_DIV, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_fields(K_REM, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_fields(K_DIVU, 1'b0, 32'h1234_5678, 32'h0, 32'h5, 32'h0);
    send_fields(K_REM, 1'b1, 32'hDEAD_BEEF, 32'h3, 32'h0, 32'h0);
    send_fields(K_NEG, 1'b0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    send_fields(K_NOT, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(K_SLT, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
  endtask

  task automatic test_wide_pair();
    send_fields(K_WMULU, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_fields(K_MFHI, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(K_WDIV, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_fields(K_MFLO, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(K_MFHI, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_fields(K_WDIVU, 1'b1, 32'h9, 32'h3, 32'h0, 32'h0);
    send_fields(K_MFHI, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
  endtask

  task automatic test_control_flow();
    send_fields(K_BEQ, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFC);
    send_fields(K_BGTZ, 1'b0, 32'h8000_0000, 32'h0, 32'h0, 32'h40);
    send_fields(K_JAL, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0040_0000);
    send_fields(K_JALR, 1'b0, 32'hFFFF_FFF0, 32'h0, 32'h0, 32'h0);
    send_fields(K_ADDR, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0);
    send_fields(K_ADDR, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0);
    send_fields(6'h3F, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // idling switched on and off in stretches
  task automatic test_random_ops(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      send_op(random_op());
    end
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold = LongHold;
    for (int unsigned i = 0; i < 8; i++) send_op(random_op());
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pair_after_reset();
    test_arith_edges();
    test_wide_pair();
    test_control_flow();
    test_backpressure();
    test_random_ops(340);
    wait_drained();
    test_random_ops(340);
    wait_drained();
    if (!failed && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mea_pkg.sv
hw/rtl/mea_iter.sv
hw/rtl/mips_execute_alu_unit.sv
sim/tb_mips_execute_alu_unit.sv
